>>> design/quaternion_multiply_rotate_defines.svh
// Assertion macros for the quaternion multiply / rotate block and its checker.
// Depends on a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef QUATERNION_MULTIPLY_ROTATE_DEFINES_SVH
`define QUATERNION_MULTIPLY_ROTATE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define QMR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("quaternion_multiply_rotate: check failed");

// Antecedent implies consequent in the next cycle.
`define QMR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("quaternion_multiply_rotate: check failed");

`endif

>>> design/qmr_pkg.sv
// Shared widths, types, sign/index tables and rounding helpers for the
// quaternion multiply / rotate pipeline. No dependencies.
package qmr_pkg;

    localparam int DATA_W      = 16;
    localparam int FRAC_W      = 14;
    localparam int MID_W       = DATA_W + 4;
    localparam int CONJ_W      = DATA_W + 1;
    localparam int PROD_W      = MID_W + CONJ_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int RND_W       = ACC_W - FRAC_W;
    localparam int N_COMP      = 4;
    localparam int IN_TDATA_W  = 2 * N_COMP * DATA_W;
    localparam int OUT_TDATA_W = N_COMP * DATA_W;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [MID_W-1:0]  t_mid;
    typedef logic signed [CONJ_W-1:0] t_conj;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [RND_W-1:0]  t_rnd;
    typedef logic [1:0]               t_idx;

    typedef enum logic {
        ACT_MUL = 1'b0,
        ACT_ROT = 1'b1
    } t_action;

    typedef struct packed {
        t_rnd val;
        logic ovf;
    } t_sat;

    localparam t_data DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam t_acc  HALF_LSB = t_acc'(1) <<< (FRAC_W - 1);

    // Hamilton product: component c sums p[k] * q[QI[c][k]], subtracting where NEG[c][k].
    localparam t_idx QI [N_COMP][N_COMP] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };
    localparam logic [N_COMP-1:0] NEG [N_COMP] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

    // Exact signed sum of four products, rounded half up to FRAC_W fraction bits.
    function automatic t_rnd round_sum(input t_prod prod [N_COMP], input logic [N_COMP-1:0] neg);
        t_acc acc;
        acc = '0;
        for (int k = 0; k < N_COMP; k++) begin
            if (neg[k]) begin
                acc = acc - t_acc'(prod[k]);
            end else begin
                acc = acc + t_acc'(prod[k]);
            end
        end
        acc = acc + HALF_LSB;
        return t_rnd'(acc >>> FRAC_W);
    endfunction

    // Clamp to a signed range of w bits and flag a clamp.
    function automatic t_sat sat_to(input t_rnd v, input int unsigned w);
        t_rnd hi_lim;
        t_rnd lo_lim;
        t_sat res;
        hi_lim  = (t_rnd'(1) <<< (w - 1)) - t_rnd'(1);
        lo_lim  = -hi_lim - t_rnd'(1);
        res.val = v;
        res.ovf = 1'b0;
        if (v > hi_lim) begin
            res.val = hi_lim;
            res.ovf = 1'b1;
        end else if (v < lo_lim) begin
            res.val = lo_lim;
            res.ovf = 1'b1;
        end
        return res;
    endfunction

endpackage

>>> design/quaternion_multiply_rotate.sv
// Quaternion Hamilton product / vector rotation, signed Q2.14, four-stage pipeline.
// Depends on qmr_pkg and qmr_qprod.
//
//  channel   dir  tdata (low bit up)                               tuser
//  s_axis    in   a_w a_x a_y a_z b_w b_x b_y b_z (16 b each)       action
//  m_axis    out  r_w r_x r_y r_z (16 b each)                       overflow
//
// One transaction per cycle sustained while the output is not stalled; the last stage register is the output register.
// Stages: first multiplier bank, sum/round/saturate, second multiplier bank, sum/round/saturate.
// Each stage advances when it is empty or the next one advances, so bubbles close up.
// Synchronous active-low reset clears the valid bits only; no clearing pass.
// An output stall holds all data in place; nothing is dropped or repeated.
module quaternion_multiply_rotate (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [qmr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // a_w,a_x,a_y,a_z,b_w,b_x,b_y,b_z
    input  logic [0:0]                         s_axis_tuser,  // action
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [qmr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // r_w,r_x,r_y,r_z
    output logic [0:0]                         m_axis_tuser   // overflow
);

    localparam int NC = qmr_pkg::N_COMP;

    logic en1, en2, en3, en4;
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v;

    // stage 1 inputs
    qmr_pkg::t_data   in_a  [NC];
    qmr_pkg::t_data   in_b  [NC];
    qmr_pkg::t_action in_act;
    qmr_pkg::t_mid    p1    [NC];
    qmr_pkg::t_conj   q1    [NC];
    qmr_pkg::t_prod   prod1 [NC][NC];

    qmr_pkg::t_prod   r_s1_prod [NC][NC];
    qmr_pkg::t_data   r_s1_a    [NC];
    qmr_pkg::t_action r_s1_act;

    // stage 2
    qmr_pkg::t_rnd    rnd1      [NC];
    qmr_pkg::t_sat    sat1_mul  [NC];
    qmr_pkg::t_sat    sat1_mid  [NC];
    qmr_pkg::t_mid    n_s2_t    [NC];
    logic [NC-1:0]    ovf1_mul, ovf1_mid;
    logic             n_s2_ovf;

    qmr_pkg::t_mid    r_s2_t    [NC];
    qmr_pkg::t_data   r_s2_a    [NC];
    qmr_pkg::t_action r_s2_act;
    logic             r_s2_ovf;

    // stage 3
    qmr_pkg::t_conj   q2    [NC];
    qmr_pkg::t_prod   prod2 [NC][NC];

    qmr_pkg::t_prod   r_s3_prod [NC][NC];
    qmr_pkg::t_data   r_s3_t    [NC];
    qmr_pkg::t_action r_s3_act;
    logic             r_s3_ovf;

    // stage 4
    qmr_pkg::t_rnd    rnd2   [NC];
    qmr_pkg::t_sat    sat2_16[NC];
    qmr_pkg::t_sat    sat2_17[NC];
    qmr_pkg::t_data   n_out  [NC];
    logic [NC-1:0]    ovf2_16, ovf2_17, at_rail;
    logic             n_out_ovf;

    qmr_pkg::t_data   r_out  [NC];
    logic             r_out_ovf;

    // ------------------------------------------------------------------ flow control
    assign en4           = !r_s4_v || m_axis_tready;
    assign en3           = !r_s3_v || en4;
    assign en2           = !r_s2_v || en3;
    assign en1           = !r_s1_v || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_v <= s_axis_tvalid;
            end
            if (en2) begin
                r_s2_v <= r_s1_v;
            end
            if (en3) begin
                r_s3_v <= r_s2_v;
            end
            if (en4) begin
                r_s4_v <= r_s3_v;
            end
        end
    end

    // ------------------------------------------------------------------ stage 1: A * B
    assign in_act = qmr_pkg::t_action'(s_axis_tuser[0]);

    for (genvar i = 0; i < NC; i++) begin : g_in
        assign in_a[i] = s_axis_tdata[i*qmr_pkg::DATA_W +: qmr_pkg::DATA_W];
        assign in_b[i] = s_axis_tdata[(NC+i)*qmr_pkg::DATA_W +: qmr_pkg::DATA_W];
        assign p1[i]   = qmr_pkg::t_mid'(in_a[i]);
        // drop the scalar of B when rotating: v is a pure quaternion
        if (i == 0) begin : g_scalar
            assign q1[i] = (in_act == qmr_pkg::ACT_ROT) ? '0 : qmr_pkg::t_conj'(in_b[i]);
        end else begin : g_vec
            assign q1[i] = qmr_pkg::t_conj'(in_b[i]);
        end
    end

    qmr_qprod u_prod1 (
        .i_p    (p1),
        .i_q    (q1),
        .o_prod (prod1)
    );

    always_ff @(posedge i_clk) begin
        if (en1 && s_axis_tvalid) begin
            r_s1_prod <= prod1;
            r_s1_a    <= in_a;
            r_s1_act  <= in_act;
        end
    end

    // ------------------------------------------------------------------ stage 2: round
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            rnd1[c]     = qmr_pkg::round_sum(r_s1_prod[c], qmr_pkg::NEG[c]);
            sat1_mul[c] = qmr_pkg::sat_to(rnd1[c], qmr_pkg::DATA_W);
            sat1_mid[c] = qmr_pkg::sat_to(rnd1[c], qmr_pkg::MID_W);
            ovf1_mul[c] = sat1_mul[c].ovf;
            ovf1_mid[c] = sat1_mid[c].ovf;
            if (r_s1_act == qmr_pkg::ACT_ROT) begin
                n_s2_t[c] = qmr_pkg::t_mid'(sat1_mid[c].val);
            end else begin
                n_s2_t[c] = qmr_pkg::t_mid'(sat1_mul[c].val);
            end
        end
        n_s2_ovf = (r_s1_act == qmr_pkg::ACT_ROT) ? (|ovf1_mid) : (|ovf1_mul);
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_s1_v) begin
            r_s2_t   <= n_s2_t;
            r_s2_a   <= r_s1_a;
            r_s2_act <= r_s1_act;
            r_s2_ovf <= n_s2_ovf;
        end
    end

    // ------------------------------------------------------------------ stage 3: T * conj(A)
    for (genvar i = 0; i < NC; i++) begin : g_conj
        if (i == 0) begin : g_scalar
            assign q2[i] = qmr_pkg::t_conj'(r_s2_a[i]);
        end else begin : g_vec
            // one bit wider, so negating the most negative value stays exact
            assign q2[i] = -qmr_pkg::t_conj'(r_s2_a[i]);
        end
    end

    qmr_qprod u_prod2 (
        .i_p    (r_s2_t),
        .i_q    (q2),
        .o_prod (prod2)
    );

    always_ff @(posedge i_clk) begin
        if (en3 && r_s2_v) begin
            r_s3_prod <= prod2;
            r_s3_act  <= r_s2_act;
            r_s3_ovf  <= r_s2_ovf;
            for (int c = 0; c < NC; c++) begin
                r_s3_t[c] <= qmr_pkg::t_data'(r_s2_t[c]);
            end
        end
    end

    // ------------------------------------------------------------------ stage 4: round, select
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            rnd2[c]    = qmr_pkg::round_sum(r_s3_prod[c], qmr_pkg::NEG[c]);
            sat2_16[c] = qmr_pkg::sat_to(rnd2[c], qmr_pkg::DATA_W);
            sat2_17[c] = qmr_pkg::sat_to(rnd2[c], qmr_pkg::DATA_W + 1);
            ovf2_16[c] = sat2_16[c].ovf;
            ovf2_17[c] = sat2_17[c].ovf;
        end
        at_rail[0] = 1'b0;
        for (int c = 1; c < NC; c++) begin
            at_rail[c] = (qmr_pkg::t_data'(sat2_16[c].val) == qmr_pkg::DATA_MAX)
                      || (qmr_pkg::t_data'(sat2_16[c].val) == qmr_pkg::DATA_MIN);
        end
        if (r_s3_act == qmr_pkg::ACT_ROT) begin
            n_out[0] = '0;
            for (int c = 1; c < NC; c++) begin
                n_out[c] = qmr_pkg::t_data'(sat2_16[c].val);
            end
            // a one-bit-wider clamp anywhere, scalar included, flags a vector part on a rail
            n_out_ovf = r_s3_ovf || (|ovf2_16[NC-1:1]) || ((|ovf2_17) && (|at_rail));
        end else begin
            n_out     = r_s3_t;
            n_out_ovf = r_s3_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r_s3_v) begin
            r_out     <= n_out;
            r_out_ovf <= n_out_ovf;
        end
    end

    assign m_axis_tvalid   = r_s4_v;
    assign m_axis_tuser[0] = r_out_ovf;

    for (genvar i = 0; i < NC; i++) begin : g_out
        assign m_axis_tdata[i*qmr_pkg::DATA_W +: qmr_pkg::DATA_W] = r_out[i];
    end

endmodule

>>> design/qmr_qprod.sv
// Sixteen partial products of a Hamilton product p*q, arranged per result component.
// Depends on qmr_pkg.
module qmr_qprod (
    input  qmr_pkg::t_mid  i_p    [qmr_pkg::N_COMP],
    input  qmr_pkg::t_conj i_q    [qmr_pkg::N_COMP],
    output qmr_pkg::t_prod o_prod [qmr_pkg::N_COMP][qmr_pkg::N_COMP]
);

    for (genvar c = 0; c < qmr_pkg::N_COMP; c++) begin : g_comp
        for (genvar k = 0; k < qmr_pkg::N_COMP; k++) begin : g_term
            assign o_prod[c][k] = qmr_pkg::t_prod'(i_p[k])
                                * qmr_pkg::t_prod'(i_q[qmr_pkg::QI[c][k]]);
        end
    end

endmodule

>>> design/qmr_checker.sv
// Port-level checks for quaternion_multiply_rotate, bound to the top level.
// Depends on qmr_pkg and quaternion_multiply_rotate_defines.svh.
`include "quaternion_multiply_rotate_defines.svh"

module qmr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [qmr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                      m_axis_tuser
);

    logic out_stall;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // hold a stalled output transaction
    `QMR_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser}))

    // an empty or draining output never blocks the input side
    `QMR_ASSERT_IMPL(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)
    `QMR_ASSERT_IMPL(a_ready_when_drain, m_axis_tready, s_axis_tready)

    // nothing comes out right after reset
    `QMR_ASSERT_IMPL(a_quiet_after_reset, $past(!i_rst_n), !m_axis_tvalid)

endmodule

bind quaternion_multiply_rotate qmr_checker u_qmr_checker (.*);

>>> tb/sv/qmr_result_checker.sv
`timescale 1ns / 1ps
// Result checker for quaternion_multiply_rotate: watches both stream channels,
// computes each product or rotation on its own and compares every result field.
// Depends on qmr_pkg for widths, data types and the action codes.
module qmr_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [qmr_pkg::IN_TDATA_W-1:0]  i_in_data,   // a_w,a_x,a_y,a_z,b_w,b_x,b_y,b_z
    input  logic [0:0]                      i_in_user,   // action
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [qmr_pkg::OUT_TDATA_W-1:0] i_out_data,  // r_w,r_x,r_y,r_z
    input  logic [0:0]                      i_out_user,  // overflow
    output int                              o_pending,
    output int                              o_errors
);
    import qmr_pkg::*;

    typedef struct packed {
        longint w;
        longint x;
        longint y;
        longint z;
    } t_quat;

    typedef struct packed {
        t_data w;
        t_data x;
        t_data y;
        t_data z;
        logic  ovf;
    } t_result;

    t_result pending_results_q[$];
    t_result oldest;
    int      mismatch_count = 0;
    int      pending_count  = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = pending_count;

    function automatic t_quat quat_from_bits(input logic [N_COMP*DATA_W-1:0] bits);
        t_quat q;
        q.w = longint'(t_data'(bits[0*DATA_W +: DATA_W]));
        q.x = longint'(t_data'(bits[1*DATA_W +: DATA_W]));
        q.y = longint'(t_data'(bits[2*DATA_W +: DATA_W]));
        q.z = longint'(t_data'(bits[3*DATA_W +: DATA_W]));
        return q;
    endfunction

    // Add half an LSB, then floor: round half up.
    function automatic longint round_frac(input longint s);
        return (s + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    function automatic logic fits(input longint v, input int w);
        return (v >= -(longint'(1) <<< (w - 1))) && (v < (longint'(1) <<< (w - 1)));
    endfunction

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi) begin
            return hi;
        end else if (v < -hi - 1) begin
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic t_quat quat_clamp(input t_quat q, input int w);
        t_quat r;
        r.w = clamp(q.w, w);
        r.x = clamp(q.x, w);
        r.y = clamp(q.y, w);
        r.z = clamp(q.z, w);
        return r;
    endfunction

    function automatic logic vec_outside(input t_quat q, input int w);
        return !fits(q.x, w) || !fits(q.y, w) || !fits(q.z, w);
    endfunction

    function automatic logic at_rail(input t_data v);
        return (v == DATA_MAX) || (v == DATA_MIN);
    endfunction

    // Exact Hamilton product p*q, each component rounded to the fraction width.
    function automatic t_quat hamilton_round(input t_quat p, input t_quat q);
        t_quat r;
        r.w = round_frac(p.w * q.w - p.x * q.x - p.y * q.y - p.z * q.z);
        r.x = round_frac(p.w * q.x + p.x * q.w + p.y * q.z - p.z * q.y);
        r.y = round_frac(p.w * q.y - p.x * q.z + p.y * q.w + p.z * q.x);
        r.z = round_frac(p.w * q.z + p.x * q.y - p.y * q.x + p.z * q.w);
        return r;
    endfunction

    function automatic t_result product_or_rotation(input t_action act, input t_quat a,
                                                    input t_quat b);
        t_quat   prod;
        t_quat   mid;
        t_quat   conj;
        t_quat   fin;
        t_quat   sat;
        t_result res;
        if (act == ACT_MUL) begin
            prod    = hamilton_round(a, b);
            sat     = quat_clamp(prod, DATA_W);
            res.w   = t_data'(sat.w);
            res.x   = t_data'(sat.x);
            res.y   = t_data'(sat.y);
            res.z   = t_data'(sat.z);
            res.ovf = !fits(prod.w, DATA_W) || vec_outside(prod, DATA_W);
        end else begin
            b.w     = 0;
            mid     = hamilton_round(a, b);
            res.ovf = !fits(mid.w, MID_W) || vec_outside(mid, MID_W);
            mid     = quat_clamp(mid, MID_W);
            // keep the conjugate exact, one bit wider than the input
            conj.w  = a.w;
            conj.x  = -a.x;
            conj.y  = -a.y;
            conj.z  = -a.z;
            fin     = hamilton_round(mid, conj);
            sat     = quat_clamp(fin, DATA_W);
            res.w   = '0;
            res.x   = t_data'(sat.x);
            res.y   = t_data'(sat.y);
            res.z   = t_data'(sat.z);
            if (vec_outside(fin, DATA_W)) begin
                res.ovf = 1'b1;
            end
            // a component past the conjugate width, scalar included, flags any rail value
            if ((!fits(fin.w, CONJ_W) || vec_outside(fin, CONJ_W)) &&
                (at_rail(res.x) || at_rail(res.y) || at_rail(res.z))) begin
                res.ovf = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                pending_results_q.push_back(product_or_rotation(
                    t_action'(i_in_user[0]),
                    quat_from_bits(i_in_data[0 +: N_COMP*DATA_W]),
                    quat_from_bits(i_in_data[N_COMP*DATA_W +: N_COMP*DATA_W])));
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_results_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result transaction with none expected, actual tdata %h",
                             $time, i_out_data);
                end else begin
                    oldest = pending_results_q.pop_front();
                    check_field("r_w", oldest.w, t_data'(i_out_data[0*DATA_W +: DATA_W]));
                    check_field("r_x", oldest.x, t_data'(i_out_data[1*DATA_W +: DATA_W]));
                    check_field("r_y", oldest.y, t_data'(i_out_data[2*DATA_W +: DATA_W]));
                    check_field("r_z", oldest.z, t_data'(i_out_data[3*DATA_W +: DATA_W]));
                    check_field("overflow", oldest.ovf, i_out_user[0]);
                end
            end
        end
        pending_count <= pending_results_q.size();
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the quaternion_multiply_rotate testbench: clock, reset, stream stimulus
// and the final verdict. Depends on qmr_pkg, the block and qmr_result_checker.
module testbench;
    import qmr_pkg::*;

    localparam t_data ONE       = 16384;  // 1.0 in Q2.14
    localparam t_data ROOT_HALF = 11585;  // cos of 45 degrees
    localparam int    PHASE_ITEMS = 545;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    int tx_idle_pct = 11;
    int rx_idle_pct = 54;
    int mul_count   = 0;
    int rot_count   = 0;
    int pending;
    int errors;

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    quaternion_multiply_rotate u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    qmr_result_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Drive one transaction and hold it until the block takes it.
    task automatic send_item(input t_action act, input t_data aw, input t_data ax,
                             input t_data ay, input t_data az, input t_data bw,
                             input t_data bx, input t_data by, input t_data bz);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bz, by, bx, bw, az, ay, ax, aw};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (act == ACT_MUL) begin
            mul_count++;
        end else begin
            rot_count++;
        end
    endtask

    // kind: 0 full range, 1 within unit magnitude, 2 small, 3 corner values
    function automatic t_data rand_comp(input int kind);
        case (kind)
            0: return t_data'($urandom);
            1: return t_data'(int'($urandom_range(32768)) - 16384);
            2: return t_data'(int'($urandom_range(512)) - 256);
            default: begin
                case ($urandom_range(6))
                    0: return DATA_MIN;
                    1: return DATA_MAX;
                    2: return '0;
                    3: return -1;
                    4: return 1;
                    5: return ONE;
                    default: return -ONE;
                endcase
            end
        endcase
    endfunction

    task automatic send_random_item();
        t_data   c [8];
        int      mix;
        t_action act;
        mix = $urandom_range(9);
        act = t_action'($urandom_range(1));
        for (int k = 0; k < 8; k++) begin
            case (mix)
                0, 1, 2, 3: c[k] = rand_comp(0);
                4, 5, 6:    c[k] = rand_comp(1);
                7:          c[k] = rand_comp(2);
                8:          c[k] = rand_comp(3);
                default:    c[k] = rand_comp($urandom_range(3));
            endcase
        end
        send_item(act, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // products: zeros, rails, basis identities, rounding at exactly half an LSB
        send_item(ACT_MUL, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(ACT_MUL, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX,
                  DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
        send_item(ACT_MUL, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN,
                  DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
        send_item(ACT_MUL, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN,
                  DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
        send_item(ACT_MUL, ONE, 0, 0, 0, 1000, -2000, 3000, -4000);
        send_item(ACT_MUL, 0, ONE, 0, 0, 0, 0, ONE, 0);
        send_item(ACT_MUL, 0, 0, ONE, 0, 0, ONE, 0, 0);
        send_item(ACT_MUL, 0, 0, 0, ONE, 0, 0, 0, ONE);
        send_item(ACT_MUL, 1, 0, 0, 0, 8192, -8192, 8191, -8193);
        send_item(ACT_MUL, -1, 0, 0, 0, 8192, -8192, 8191, -8193);

        // rotations: zero and identity, quarter turns, most negative parts in the
        // conjugate, non-unit scaling, a nonzero scalar in B that must be ignored
        send_item(ACT_ROT, 0, 0, 0, 0, 0, DATA_MAX, DATA_MAX, DATA_MAX);
        send_item(ACT_ROT, ONE, 0, 0, 0, DATA_MAX, DATA_MAX, DATA_MIN, 1);
        send_item(ACT_ROT, ROOT_HALF, 0, 0, ROOT_HALF, 0, ONE, 0, 0);
        send_item(ACT_ROT, ROOT_HALF, ROOT_HALF, 0, 0, DATA_MIN, 0, ONE, -ONE);
        send_item(ACT_ROT, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN,
                  0, DATA_MAX, DATA_MAX, DATA_MAX);
        send_item(ACT_ROT, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX,
                  0, DATA_MIN, DATA_MIN, DATA_MIN);
        send_item(ACT_ROT, 0, DATA_MIN, DATA_MIN, DATA_MIN, 0, 1, 2, 3);
        send_item(ACT_ROT, DATA_MAX, 0, 0, 0, 0, 4096, -4096, 8192);
        send_item(ACT_ROT, 8192, 0, 0, 0, 0, ONE, -ONE, 100);
        send_item(ACT_ROT, ONE, ONE, 0, 0, 0, ONE, ONE, ONE);

        for (int n = 0; n < PHASE_ITEMS - 20; n++) send_random_item();
        tx_idle_pct = 54;
        rx_idle_pct = 11;
        for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d multiply and %0d rotate transactions: directed extremes, then",
                 mul_count, rot_count);
        $display("random operands under three sender/receiver stall mixes.");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/qmr_pkg.sv
design/qmr_qprod.sv
design/quaternion_multiply_rotate.sv
design/qmr_checker.sv
tb/sv/qmr_result_checker.sv
tb/sv/testbench.sv
